### sv/mts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_pkg
// Types, constants and helpers shared by the task scheduler files.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int unsigned TASK_SLOTS   = 16;
    localparam int unsigned SLOT_W       = 4;
    localparam int unsigned TICK_W       = 5;
    localparam int unsigned PRIO_W       = 2;
    localparam int unsigned LEVELS       = 4;
    localparam int unsigned SLICE_UNIT   = 5;
    localparam logic [PRIO_W-1:0] LOWEST_LEVEL = 2'd3;
    localparam logic [PRIO_W-1:0] IDLE_LEVEL   = 2'd0;

    localparam logic CMD_SCHEDULE = 1'b0;
    localparam logic CMD_WRITE    = 1'b1;

    localparam logic [SLOT_W-1:0] IDLE_SLOT_RESET = 4'd1;

    typedef enum logic [1:0] {
        TS_READY   = 2'd0,
        TS_RUNNING = 2'd1,
        TS_BLOCKED = 2'd2,
        TS_DEAD    = 2'd3
    } task_state_t;

    function automatic logic [TICK_W-1:0] fresh_slice(input logic [PRIO_W-1:0] prio);
        logic [TICK_W-1:0] lvl;
        lvl = TICK_W'(prio) + TICK_W'(1);
        return TICK_W'(lvl * TICK_W'(SLICE_UNIT));
    endfunction

endpackage

### sv/mts_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mts_if
// Valid/ready channels for scheduler commands and scheduling results.
// ----------------------------------------------------------------------------
interface mts_in_if;
    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [mts_pkg::SLOT_W-1:0]  slot_index;
    logic                        slot_present;
    logic [1:0]                  new_state;
    logic [mts_pkg::PRIO_W-1:0]  new_priority;
    logic [mts_pkg::TICK_W-1:0]  new_ticks;

    modport source (output valid, command, slot_index, slot_present, new_state,
                    new_priority, new_ticks, input ready);
    modport sink   (input valid, command, slot_index, slot_present, new_state,
                    new_priority, new_ticks, output ready);
endinterface

interface mts_out_if;
    logic                        valid;
    logic                        ready;
    logic [mts_pkg::SLOT_W-1:0]  chosen_slot;
    logic                        switched;
    logic [mts_pkg::SLOT_W-1:0]  previous_slot;
    logic [mts_pkg::PRIO_W-1:0]  chosen_priority;
    logic [mts_pkg::TICK_W-1:0]  chosen_ticks;

    modport source (output valid, chosen_slot, switched, previous_slot,
                    chosen_priority, chosen_ticks, input ready);
    modport sink   (input valid, chosen_slot, switched, previous_slot,
                    chosen_priority, chosen_ticks, output ready);
endinterface

### sv/multilevel_task_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multilevel_task_scheduler
// Multilevel feedback scheduler over a 16-entry task slot table.
// ----------------------------------------------------------------------------
// A write transaction goes from acceptance straight to emit. A schedule
// transaction whose running task keeps its slice goes from tick to emit; one
// that reselects walks the slot table one slot per cycle through a single
// read port, then picks, reloads an empty slice and, if the choice changed,
// demotes the old task and promotes the new one. A new transaction is taken
// only while the sequencer is idle; a finished result sits in an output
// register and holds off only the next transaction's emit, not its acceptance.
// ----------------------------------------------------------------------------
module multilevel_task_scheduler (
    input  logic                       clk,
    input  logic                       rst_n,
    mts_in_if.sink                     in_ch,
    mts_out_if.source                  out_ch,
    input  logic                       cfg_we,
    input  logic [mts_pkg::SLOT_W-1:0] cfg_wdata
);

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_TICK    = 9'b000000010,
        S_INIT    = 9'b000000100,
        S_SCAN    = 9'b000001000,
        S_PICK    = 9'b000010000,
        S_FIX     = 9'b000100000,
        S_DEMOTE  = 9'b001000000,
        S_PROMOTE = 9'b010000000,
        S_EMIT    = 9'b100000000
    } fsm_t;

    fsm_t state_reg, state_next;

    logic                        present_reg [mts_pkg::TASK_SLOTS];
    mts_pkg::task_state_t        tstate_reg  [mts_pkg::TASK_SLOTS];
    logic [mts_pkg::PRIO_W-1:0]  prio_reg    [mts_pkg::TASK_SLOTS];
    logic [mts_pkg::TICK_W-1:0]  ticks_reg   [mts_pkg::TASK_SLOTS];

    logic [mts_pkg::SLOT_W-1:0]  running_reg, running_next;
    logic [mts_pkg::SLOT_W-1:0]  cursor_reg, cursor_next;
    logic                        cursor_valid_reg, cursor_valid_next;
    logic [mts_pkg::SLOT_W-1:0]  idle_slot_reg;
    logic [mts_pkg::SLOT_W-1:0]  prev_reg, prev_next;
    logic [mts_pkg::SLOT_W-1:0]  sel_reg, sel_next;
    logic                        use_idle_reg, use_idle_next;
    logic [mts_pkg::SLOT_W-1:0]  scan_start_reg, scan_start_next;
    logic [mts_pkg::SLOT_W-1:0]  scan_cnt_reg, scan_cnt_next;
    logic                        found_reg [mts_pkg::LEVELS];
    logic                        found_next [mts_pkg::LEVELS];
    logic [mts_pkg::SLOT_W-1:0]  hit_reg [mts_pkg::LEVELS];
    logic [mts_pkg::SLOT_W-1:0]  hit_next [mts_pkg::LEVELS];

    logic                        out_valid_reg, out_valid_next;
    logic [mts_pkg::SLOT_W-1:0]  out_chosen_reg, out_chosen_next;
    logic                        out_switched_reg, out_switched_next;
    logic [mts_pkg::SLOT_W-1:0]  out_prev_reg, out_prev_next;
    logic [mts_pkg::PRIO_W-1:0]  out_prio_reg, out_prio_next;
    logic [mts_pkg::TICK_W-1:0]  out_ticks_reg, out_ticks_next;

    // single table read port
    logic [mts_pkg::SLOT_W-1:0]  rd_addr;
    logic                        rd_present;
    mts_pkg::task_state_t        rd_state;
    logic [mts_pkg::PRIO_W-1:0]  rd_prio;
    logic [mts_pkg::TICK_W-1:0]  rd_ticks;
    logic                        rd_ready;

    // single table write port
    logic [mts_pkg::SLOT_W-1:0]  wr_addr;
    logic                        we_present, we_state, we_prio, we_ticks;
    logic                        wd_present;
    mts_pkg::task_state_t        wd_state;
    logic [mts_pkg::PRIO_W-1:0]  wd_prio;
    logic [mts_pkg::TICK_W-1:0]  wd_ticks;

    logic [mts_pkg::TICK_W-1:0]  ticks_dec;
    logic [mts_pkg::SLOT_W-1:0]  scan_slot;
    logic                        in_acc;

    assign in_ch.ready     = (state_reg == S_IDLE);
    assign in_acc          = in_ch.valid && in_ch.ready;
    assign scan_slot       = scan_start_reg + scan_cnt_reg;
    assign rd_present      = present_reg[rd_addr];
    assign rd_state        = tstate_reg[rd_addr];
    assign rd_prio         = prio_reg[rd_addr];
    assign rd_ticks        = ticks_reg[rd_addr];
    assign rd_ready        = rd_present && (rd_state == mts_pkg::TS_READY);
    assign ticks_dec       = rd_ticks - mts_pkg::TICK_W'(1);

    assign out_ch.valid           = out_valid_reg;
    assign out_ch.chosen_slot     = out_chosen_reg;
    assign out_ch.switched        = out_switched_reg;
    assign out_ch.previous_slot   = out_prev_reg;
    assign out_ch.chosen_priority = out_prio_reg;
    assign out_ch.chosen_ticks    = out_ticks_reg;

    always_comb
    begin
        unique case (state_reg)
            S_TICK, S_DEMOTE: rd_addr = running_reg;
            S_INIT:           rd_addr = cursor_reg;
            S_SCAN:           rd_addr = scan_slot;
            default:          rd_addr = sel_reg;
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        running_next      = running_reg;
        cursor_next       = cursor_reg;
        cursor_valid_next = cursor_valid_reg;
        prev_next         = prev_reg;
        sel_next          = sel_reg;
        use_idle_next     = use_idle_reg;
        scan_start_next   = scan_start_reg;
        scan_cnt_next     = scan_cnt_reg;
        found_next        = found_reg;
        hit_next          = hit_reg;
        out_valid_next    = out_valid_reg && !out_ch.ready;
        out_chosen_next   = out_chosen_reg;
        out_switched_next = out_switched_reg;
        out_prev_next     = out_prev_reg;
        out_prio_next     = out_prio_reg;
        out_ticks_next    = out_ticks_reg;

        wr_addr    = rd_addr;
        we_present = 1'b0;
        we_state   = 1'b0;
        we_prio    = 1'b0;
        we_ticks   = 1'b0;
        wd_present = in_ch.slot_present;
        wd_state   = mts_pkg::TS_READY;
        wd_prio    = rd_prio;
        wd_ticks   = rd_ticks;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    prev_next = running_reg;
                    sel_next  = running_reg;
                    if (in_ch.command == mts_pkg::CMD_WRITE)
                    begin
                        wr_addr    = in_ch.slot_index;
                        we_present = 1'b1;
                        we_state   = 1'b1;
                        we_prio    = 1'b1;
                        we_ticks   = 1'b1;
                        wd_state   = mts_pkg::task_state_t'(in_ch.new_state);
                        wd_prio    = in_ch.new_priority;
                        wd_ticks   = in_ch.new_ticks;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_TICK;
                    end
                end
            end
            S_TICK:
            begin
                state_next = S_INIT;
                if (rd_state == mts_pkg::TS_RUNNING && rd_ticks != '0)
                begin
                    we_ticks = 1'b1;
                    if (ticks_dec != '0)
                    begin
                        wd_ticks   = ticks_dec;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        wd_ticks = mts_pkg::fresh_slice(rd_prio);
                        if (rd_prio != mts_pkg::LOWEST_LEVEL)
                        begin
                            we_prio = 1'b1;
                            wd_prio = rd_prio + mts_pkg::PRIO_W'(1);
                        end
                    end
                end
            end
            S_INIT:
            begin
                // a cursor on an empty slot is dropped until a later pick sets it again
                cursor_valid_next = cursor_valid_reg && rd_present;
                scan_start_next   = cursor_valid_next ?
                                    cursor_reg + mts_pkg::SLOT_W'(1) : '0;
                scan_cnt_next     = '0;
                for (int i = 0; i < mts_pkg::LEVELS; i++)
                begin
                    found_next[i] = 1'b0;
                    hit_next[i]   = '0;
                end
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (rd_ready)
                begin
                    if (rd_prio == mts_pkg::IDLE_LEVEL)
                    begin
                        // fallback takes the lowest index, not round-robin order
                        if (!found_reg[0] || scan_slot < hit_reg[0])
                        begin
                            found_next[0] = 1'b1;
                            hit_next[0]   = scan_slot;
                        end
                    end
                    else if (!found_reg[rd_prio])
                    begin
                        found_next[rd_prio] = 1'b1;
                        hit_next[rd_prio]   = scan_slot;
                    end
                end
                scan_cnt_next = scan_cnt_reg + mts_pkg::SLOT_W'(1);
                if (scan_cnt_reg == mts_pkg::SLOT_W'(mts_pkg::TASK_SLOTS - 1))
                begin
                    state_next = S_PICK;
                end
            end
            S_PICK:
            begin
                use_idle_next = 1'b0;
                priority if (found_reg[1])
                begin
                    sel_next          = hit_reg[1];
                    cursor_next       = hit_reg[1];
                    cursor_valid_next = 1'b1;
                end
                else if (found_reg[2])
                begin
                    sel_next          = hit_reg[2];
                    cursor_next       = hit_reg[2];
                    cursor_valid_next = 1'b1;
                end
                else if (found_reg[3])
                begin
                    sel_next          = hit_reg[3];
                    cursor_next       = hit_reg[3];
                    cursor_valid_next = 1'b1;
                end
                else if (found_reg[0])
                begin
                    sel_next = hit_reg[0];
                end
                else
                begin
                    sel_next      = idle_slot_reg;
                    use_idle_next = 1'b1;
                end
                state_next = S_FIX;
            end
            S_FIX:
            begin
                if (use_idle_reg && rd_state != mts_pkg::TS_READY
                    && rd_state != mts_pkg::TS_RUNNING)
                begin
                    we_state = 1'b1;
                    wd_state = mts_pkg::TS_READY;
                end
                if (rd_ticks == '0)
                begin
                    we_ticks = 1'b1;
                    wd_ticks = mts_pkg::fresh_slice(rd_prio);
                end
                state_next = (sel_reg != running_reg) ? S_DEMOTE : S_EMIT;
            end
            S_DEMOTE:
            begin
                if (rd_state == mts_pkg::TS_RUNNING)
                begin
                    we_state = 1'b1;
                    wd_state = mts_pkg::TS_READY;
                end
                state_next = S_PROMOTE;
            end
            S_PROMOTE:
            begin
                wr_addr      = sel_reg;
                we_state     = 1'b1;
                wd_state     = mts_pkg::TS_RUNNING;
                running_next = sel_reg;
                state_next   = S_EMIT;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next    = 1'b1;
                    out_chosen_next   = sel_reg;
                    out_switched_next = (sel_reg != prev_reg);
                    out_prev_next     = prev_reg;
                    out_prio_next     = rd_prio;
                    out_ticks_next    = rd_ticks;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            running_reg      <= '0;
            cursor_reg       <= '0;
            cursor_valid_reg <= 1'b0;
            idle_slot_reg    <= mts_pkg::IDLE_SLOT_RESET;
            out_valid_reg    <= 1'b0;
            for (int i = 0; i < mts_pkg::TASK_SLOTS; i++)
            begin
                present_reg[i] <= 1'b0;
                tstate_reg[i]  <= mts_pkg::TS_READY;
                prio_reg[i]    <= '0;
                ticks_reg[i]   <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            running_reg      <= running_next;
            cursor_reg       <= cursor_next;
            cursor_valid_reg <= cursor_valid_next;
            out_valid_reg    <= out_valid_next;
            if (cfg_we)
            begin
                idle_slot_reg <= cfg_wdata;
            end
            for (int i = 0; i < mts_pkg::TASK_SLOTS; i++)
            begin
                if (wr_addr == mts_pkg::SLOT_W'(i))
                begin
                    if (we_present)
                    begin
                        present_reg[i] <= wd_present;
                    end
                    if (we_state)
                    begin
                        tstate_reg[i] <= wd_state;
                    end
                    if (we_prio)
                    begin
                        prio_reg[i] <= wd_prio;
                    end
                    if (we_ticks)
                    begin
                        ticks_reg[i] <= wd_ticks;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg         <= prev_next;
        sel_reg          <= sel_next;
        use_idle_reg     <= use_idle_next;
        scan_start_reg   <= scan_start_next;
        scan_cnt_reg     <= scan_cnt_next;
        found_reg        <= found_next;
        hit_reg          <= hit_next;
        out_chosen_reg   <= out_chosen_next;
        out_switched_reg <= out_switched_next;
        out_prev_reg     <= out_prev_next;
        out_prio_reg     <= out_prio_next;
        out_ticks_reg    <= out_ticks_next;
    end

endmodule
